FILE: src/bgcm_pkg.sv
// Shared constants and types for the bounded greedy change maker.
`default_nettype none
package bgcm_pkg;
    localparam int MAX_COINS = 8;
    localparam int IDX_W     = $clog2(MAX_COINS);
    localparam int CNT_W     = $clog2(MAX_COINS + 1);
    localparam int VAL_W     = 16;
    localparam int AMT_W     = 24;
    localparam int USED_W    = 4;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_REQ  = 1'b1;

    typedef struct packed {
        logic load;     // insert coin into sorted table
        logic start;    // latch amount, reset walk
        logic div_go;   // start division for current entry
        logic commit;   // apply quotient of current entry
        logic clear;    // empty the table
    } bgcm_cmd_t;

    typedef struct packed {
        logic            full;
        logic            empty;
        logic            div_done;
        logic            last_entry;
    } bgcm_sts_t;
endpackage
`default_nettype wire

FILE: src/bgcm_datapath.sv
// Coin table, serial divider and result formation.
`default_nettype none
module bgcm_datapath
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  bgcm_pkg::bgcm_cmd_t     cmd,
    output bgcm_pkg::bgcm_sts_t     sts,
    input  wire [15:0]              coin_value,
    input  wire [15:0]              coin_limit,
    input  wire [23:0]              amount,
    output logic [15:0]             res_value,
    output logic [15:0]             res_taken,
    output logic                    res_achieved,
    output logic [23:0]             res_paid,
    output logic [3:0]              res_used
);
    import bgcm_pkg::*;

    logic [VAL_W-1:0] val_mem [MAX_COINS];
    logic [VAL_W-1:0] lim_mem [MAX_COINS];
    logic [CNT_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [AMT_W-1:0] amt_reg, rem_reg, rem_next, paid_reg, paid_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic [AMT_W-1:0] quo_reg, dr_reg;
    logic [VAL_W:0]   part_reg;
    logic [4:0]       step_reg;
    logic             busy_reg;
    logic [VAL_W-1:0] cur_val, cur_lim;
    logic [VAL_W:0]   trial;
    logic [AMT_W-1:0] take;
    logic [39:0]      prod;
    logic [MAX_COINS-1:0] below;

    assign cur_val = val_mem[idx_reg];
    assign cur_lim = lim_mem[idx_reg];

    // entry k is at or past the insertion point: unused, or below the new value
    always_comb
    begin
        for (int k = 0; k < MAX_COINS; k++)
            below[k] = (CNT_W'(k) >= n_reg) || (val_mem[k] < coin_value);
    end

    // insertion: entries from the insertion point on shift down by one
    always_ff @(posedge clk)
    begin
        if (cmd.load && !sts.full)
        begin
            if (below[0])
            begin
                val_mem[0] <= coin_value;
                lim_mem[0] <= coin_limit;
            end
            for (int k = 1; k < MAX_COINS; k++)
            begin
                if (below[k] && !below[k-1])
                begin
                    val_mem[k] <= coin_value;
                    lim_mem[k] <= coin_limit;
                end
                else if (below[k])
                begin
                    val_mem[k] <= val_mem[k-1];
                    lim_mem[k] <= lim_mem[k-1];
                end
            end
        end
    end

    always_comb
    begin
        n_next = n_reg;
        if (cmd.clear)
            n_next = '0;
        else if (cmd.load && !sts.full)
            n_next = n_reg + 1'b1;
    end

    // restoring divider, one quotient bit per cycle
    assign trial = {part_reg[VAL_W-1:0], dr_reg[AMT_W-1]} - {1'b0, cur_val};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            n_reg <= n_next;
            if (cmd.div_go)
            begin
                busy_reg <= 1'b1;
                step_reg <= 5'(AMT_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == 5'd1)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_go)
        begin
            dr_reg   <= rem_reg;
            part_reg <= '0;
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            dr_reg <= {dr_reg[AMT_W-2:0], 1'b0};
            if (!trial[VAL_W])
            begin
                part_reg <= trial;
                quo_reg  <= {quo_reg[AMT_W-2:0], 1'b1};
            end
            else
            begin
                part_reg <= {part_reg[VAL_W-1:0], dr_reg[AMT_W-1]};
                quo_reg  <= {quo_reg[AMT_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        sts.div_done   = !busy_reg && !cmd.div_go;
        sts.full       = (n_reg == CNT_W'(MAX_COINS));
        sts.empty      = (n_reg == '0);
        sts.last_entry = ({1'b0, idx_reg} == CNT_W'(n_reg - 1'b1));
    end

    // zero value coin: quotient is meaningless, force zero; else clamp to the coin limit
    always_comb
    begin
        if (cur_val == '0)
            take = '0;
        else if (quo_reg > {8'd0, cur_lim})
            take = {8'd0, cur_lim};
        else
            take = quo_reg;
    end
    assign prod = take * cur_val;

    always_comb
    begin
        rem_next  = rem_reg;
        paid_next = paid_reg;
        used_next = used_reg;
        idx_next  = idx_reg;
        if (cmd.start)
        begin
            rem_next  = amount;
            paid_next = '0;
            used_next = '0;
            idx_next  = '0;
        end
        else if (cmd.commit)
        begin
            rem_next  = rem_reg - prod[AMT_W-1:0];
            paid_next = paid_reg + prod[AMT_W-1:0];
            if (take != '0 && used_reg != 4'hF)
                used_next = used_reg + 1'b1;
            if (!sts.last_entry)
                idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        paid_reg <= paid_next;
        used_reg <= used_next;
        idx_reg  <= idx_next;
        if (cmd.start)
            amt_reg <= amount;
    end

    // result payload, taken from the entry under commit
    always_comb
    begin
        res_value    = sts.empty ? '0 : cur_val;
        res_taken    = sts.empty ? '0 : take[VAL_W-1:0];
        res_paid     = sts.empty ? '0 : paid_next;
        res_used     = sts.empty ? '0 : used_next;
        res_achieved = sts.empty ? (amt_reg == '0) : (paid_next == amt_reg);
    end
endmodule
`default_nettype wire

FILE: src/bgcm_ctrl.sv
// Sequencer for loads and change requests.
`default_nettype none
module bgcm_ctrl
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_fire,
    input  wire                  in_op,
    input  bgcm_pkg::bgcm_sts_t  sts,
    output bgcm_pkg::bgcm_cmd_t  cmd,
    output logic                 in_ready,
    output logic                 res_load,
    output logic                 res_last,
    input  wire                  out_free
);
    import bgcm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GO   = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        res_load   = 1'b0;
        res_last   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    if (in_op == OP_LOAD)
                        cmd.load = 1'b1;
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_GO;
                    end
                end
            end
            ST_GO:
            begin
                if (sts.empty)
                    state_next = ST_EMIT;
                else
                begin
                    cmd.div_go = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
                if (sts.div_done)
                    state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    res_load = 1'b1;
                    res_last = sts.empty || sts.last_entry;
                    if (!sts.empty)
                        cmd.commit = 1'b1;
                    if (res_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_GO;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

FILE: src/bounded_greedy_change_maker.sv
// Top level of the bounded greedy change maker.
//
//  channel  dir  beat fields
//  s_axis   in   tuser: op; tdata: coin_value, coin_limit, amount (56 bits)
//  m_axis   out  tdata: coin_value_out, taken, achieved, paid_total, types_used;
//                tlast: last
//
// A load is written without leaving the idle state. A request walks the table
// entry by entry: a 24-step restoring divider (one quotient bit per cycle) sets
// the pace, plus issue and emit. Output is a one-beat register; a stalled m_axis
// holds the walk in its emit state. Reset clears the entry count and the sequencer.
`default_nettype none
module bounded_greedy_change_maker
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] op
    input  wire         s_axis_tuser,
    // [15:0] coin_value, [31:16] coin_limit, [55:32] amount
    input  wire [55:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [15:0] coin_value_out, [31:16] taken, [32] achieved,
    // [56:33] paid_total, [60:57] types_used, rest zero
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import bgcm_pkg::*;

    bgcm_cmd_t   cmd;
    bgcm_sts_t   sts;
    logic        in_fire, res_load, res_last, out_free;
    logic [15:0] res_value, res_taken;
    logic        res_achieved;
    logic [23:0] res_paid;
    logic [3:0]  res_used;
    logic        ovalid_reg;
    logic [63:0] odata_reg;
    logic        olast_reg;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    // output register empties or drains this cycle
    assign out_free = !ovalid_reg || m_axis_tready;

    bgcm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_op    (s_axis_tuser),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (s_axis_tready),
        .res_load (res_load),
        .res_last (res_last),
        .out_free (out_free)
    );

    bgcm_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .coin_value   (s_axis_tdata[15:0]),
        .coin_limit   (s_axis_tdata[31:16]),
        .amount       (s_axis_tdata[55:32]),
        .res_value    (res_value),
        .res_taken    (res_taken),
        .res_achieved (res_achieved),
        .res_paid     (res_paid),
        .res_used     (res_used)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (res_load)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    // summary fields appear only on the last beat
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            olast_reg <= res_last;
            odata_reg <= {3'd0,
                          res_last ? res_used : 4'd0,
                          res_last ? res_paid : 24'd0,
                          res_last ? res_achieved : 1'b0,
                          res_taken, res_value};
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");
    a_nobusy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input accepted mid request");
    a_sumlast: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[63:32] == 32'd0)
        else $error("summary fields on non-last beat");
endmodule
`default_nettype wire

FILE: tb/bgcm_checker.sv
// Checker: predicts change-maker results from the input beats and compares output beats.
module bgcm_checker
    import bgcm_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire         s_axis_tuser,
    input  wire [55:0]  s_axis_tdata,
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire [63:0]  m_axis_tdata,
    input  wire         m_axis_tlast,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VAL_W-1:0]  coin;
        logic [15:0]       taken;
        logic              last;
        logic              achieved;
        logic [AMT_W-1:0]  paid;
        logic [USED_W-1:0] used;
    } change_beat_t;

    logic [VAL_W-1:0] coin_vals [MAX_COINS];
    logic [15:0]      coin_lims [MAX_COINS];
    int               coin_cnt;
    change_beat_t     change_q [$];

    // sorted insert, equal values keep load order
    task automatic load_coin(input logic [15:0] v, input logic [15:0] l);
        int pos;
        pos = 0;
        if (coin_cnt >= MAX_COINS)
            return;
        while (pos < coin_cnt && coin_vals[pos] >= v)
            pos++;
        for (int k = coin_cnt; k > pos; k--)
        begin
            coin_vals[k] = coin_vals[k-1];
            coin_lims[k] = coin_lims[k-1];
        end
        coin_vals[pos] = v;
        coin_lims[pos] = l;
        coin_cnt++;
    endtask

    task automatic make_change(input logic [AMT_W-1:0] amt);
        longint       rem, paid, take;
        int           used;
        change_beat_t b;
        rem  = amt;
        paid = 0;
        used = 0;
        if (coin_cnt == 0)
        begin
            b = '0;
            b.last     = 1'b1;
            b.achieved = (amt == 0);
            change_q = {change_q, b};
            return;
        end
        for (int i = 0; i < coin_cnt; i++)
        begin
            take = 0;
            if (coin_vals[i] != 0)
            begin
                take = rem / coin_vals[i];
                if (take > coin_lims[i])
                    take = coin_lims[i];
                rem  -= take * coin_vals[i];
                paid += take * coin_vals[i];
                if (take != 0 && used < 15)
                    used++;
            end
            b = '0;
            b.coin  = coin_vals[i];
            b.taken = take[15:0];
            if (i == coin_cnt - 1)
            begin
                b.last     = 1'b1;
                b.achieved = (paid == amt);
                b.paid     = paid[AMT_W-1:0];
                b.used     = used[USED_W-1:0];
            end
            change_q = {change_q, b};
        end
        coin_cnt = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        change_beat_t got, want;
        if (!rst_n)
        begin
            coin_cnt    = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == OP_LOAD)
                    load_coin(s_axis_tdata[15:0], s_axis_tdata[31:16]);
                else
                    make_change(s_axis_tdata[55:32]);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.coin     = m_axis_tdata[15:0];
                got.taken    = m_axis_tdata[31:16];
                got.achieved = m_axis_tdata[32];
                got.paid     = m_axis_tdata[56:33];
                got.used     = m_axis_tdata[60:57];
                got.last     = m_axis_tlast;
                if (change_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected beat: %p", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = change_q.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p, actual %p", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= change_q.size();
        end
    end
endmodule

FILE: tb/tb_bounded_greedy_change_maker.sv
// Testbench top: drives loads and change requests, applies backpressure, reports verdict.
module tb_bounded_greedy_change_maker;
    timeunit 1ns;
    timeprecision 1ps;
    import bgcm_pkg::*;

    localparam int N_ITEMS   = 310;
    localparam int WD_LIMIT  = 20000;  // idle cycles
    localparam int HOLD_LEN  = 600;    // long sink hold-off

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic        s_axis_tuser = 1'b0;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          fail_count, pending;
    bit          hold_req  = 1'b0;   // stimulus asks the sink for a long stall
    bit          hold_done = 1'b0;
    int          idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bounded_greedy_change_maker u_top (.*);

    bgcm_checker u_chk (.*);

    // one beat on the slave side; gap drawn before each beat, valid stays up
    // across back-to-back beats
    task automatic send_beat(input logic op, input logic [15:0] v,
                             input logic [15:0] l, input logic [23:0] amt);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;                  // stretches with no idling
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tuser  <= op;
        s_axis_tdata  <= {amt, l, v};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic load(input logic [15:0] v, input logic [15:0] l);
        send_beat(OP_LOAD, v, l, 24'd0);
    endtask

    task automatic request(input logic [23:0] amt);
        send_beat(OP_REQ, 16'($urandom), 16'($urandom), amt);
    endtask

    // sink: random stall per beat, plus one long hold-off on request
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
                hold_req = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (gap != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int nload;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed: empty table, zero and nonzero amount
        request(24'd0);
        request(24'hFFFFFF);
        // zero-value coin, zero count, equal values, extremes
        load(16'd0, 16'd5);
        load(16'd5, 16'd0);
        load(16'hFFFF, 16'hFFFF);
        load(16'd1, 16'hFFFF);
        load(16'd25, 16'd3);
        load(16'd25, 16'd1);
        request(24'hFFFFFF);
        // full table plus ignored extra loads, amount not met
        for (int i = 0; i < 10; i++)
            load(16'(10 + i), 16'd1);
        request(24'd7);
        load(16'd3, 16'd2);
        request(24'd6);

        // random: up to ten loads per table, then a request of random amount
        for (int n = 0; n < N_ITEMS - 22; )
        begin
            nload = $urandom_range(0, 10);
            if (n >= 120 && !hold_done)
            begin
                hold_req  = 1'b1;    // sink stalls for its long hold-off
                hold_done = 1'b1;
            end
            for (int i = 0; i < nload; i++)
            begin
                case ($urandom_range(0, 3))
                    0: load(16'($urandom), 16'($urandom));
                    1: load(16'($urandom_range(0, 50)), 16'($urandom_range(0, 20)));
                    default: load(16'($urandom_range(1, 1000)), 16'($urandom_range(0, 40)));
                endcase
                n++;
            end
            case ($urandom_range(0, 2))
                0: request(24'($urandom));
                1: request(24'($urandom_range(0, 2000)));
                default: request(24'($urandom_range(0, 60000)));
            endcase
            n++;
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

FILE: filelist.f
src/bgcm_pkg.sv
src/bgcm_datapath.sv
src/bgcm_ctrl.sv
src/bounded_greedy_change_maker.sv
tb/bgcm_checker.sv
tb/tb_bounded_greedy_change_maker.sv
